FILE: hw/rtl/total_return_index_chain_macros.svh
// Assertion macros for the total return index chain.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef TOTAL_RETURN_INDEX_CHAIN_MACROS_SVH
`define TOTAL_RETURN_INDEX_CHAIN_MACROS_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge out of reset.
`define TRC_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a condition holds in the same cycle as a trigger.
`define TRC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define TRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TRC_ASSERT(lbl, cond, msg)
`define TRC_ASSERT_IMPL(lbl, ante, cons, msg)
`define TRC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/trc_pkg.sv
package trc_pkg;

    localparam int PRICE_W              = 48;
    localparam int FACTOR_W             = 40;
    localparam int RETURN_W             = 48;
    localparam int FACTOR_FRAC_BITS     = 24;
    localparam int RETURN_FRAC_BITS_DEF = 32;
    localparam int MAG_W                = 48;
    localparam int CHUNK_W              = 16;
    localparam int CHUNKS               = MAG_W / CHUNK_W;
    localparam int PROD_W               = 2 * MAG_W;
    localparam int WIDE_W               = 128;

    localparam logic [WIDE_W-1:0] SAT_NEG_LIM = WIDE_W'(48'h8000_0000_0000);
    localparam logic [WIDE_W-1:0] SAT_POS_LIM = WIDE_W'(48'h7FFF_FFFF_FFFF);

    typedef struct packed {
        logic                       series_start;
        logic signed [PRICE_W-1:0]  close_price;
        logic                       close_finite;
        logic signed [FACTOR_W-1:0] split_factor;
        logic                       factor_finite;
        logic signed [PRICE_W-1:0]  dividend_amount;
        logic                       dividend_finite;
    } sample_t;

    typedef struct packed {
        logic signed [PRICE_W-1:0]  adjusted_close;
        logic                       adjusted_known;
        logic signed [RETURN_W-1:0] daily_return;
        logic signed [PRICE_W-1:0]  index_level;
        logic                       cell_valid;
    } result_t;

    typedef enum logic [1:0] {
        MSEL_CLOSE    = 2'd0,
        MSEL_DIVIDEND = 2'd1,
        MSEL_INDEX    = 2'd2
    } mul_sel_t;

    typedef struct packed {
        logic       load_sample;
        logic       mul_clear;
        logic       mul_step;
        mul_sel_t   mul_sel;
        logic [1:0] chunk;
        logic       s_capture;
        logic       div_load;
        logic       div_step;
        logic       ret_capture;
        logic       out_write;
    } cmd_t;

    typedef struct packed {
        logic cell_ok;
        logic chain_ok;
    } dp_status_t;

    function automatic logic [MAG_W-1:0] mag48(input logic signed [MAG_W-1:0] a);
        logic [MAG_W-1:0] x;
        x = a;
        return a[MAG_W-1] ? (~x + MAG_W'(1)) : x;
    endfunction

    // Saturate a magnitude with a sign to the signed 48-bit range.
    function automatic logic signed [PRICE_W-1:0] sat48(input logic [WIDE_W-1:0] m,
                                                        input logic neg);
        logic [PRICE_W-1:0] lo;
        lo = m[PRICE_W-1:0];
        if (neg)
        begin
            if (m > SAT_NEG_LIM)
                return SAT_NEG_LIM[PRICE_W-1:0];
            return ~lo + PRICE_W'(1);
        end
        if (m > SAT_POS_LIM)
            return SAT_POS_LIM[PRICE_W-1:0];
        return lo;
    endfunction

endpackage

FILE: hw/rtl/trc_stream_if.sv
interface trc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/trc_datapath.sv
module trc_datapath #(
    parameter int RETURN_FRAC_BITS = trc_pkg::RETURN_FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  trc_pkg::cmd_t       cmd,
    input  trc_pkg::sample_t    sample_data,
    output trc_pkg::dp_status_t status,
    output trc_pkg::result_t    result_data
);
    import trc_pkg::*;

    localparam int NUM_W = MAG_W + 1 + RETURN_FRAC_BITS;
    localparam int DIV_W = NUM_W + (NUM_W % 2);
    localparam int REM_W = MAG_W - 1;
    localparam logic signed [MAG_W:0] ONE_Q = (MAG_W+1)'(1) << RETURN_FRAC_BITS;

    sample_t                   smp_reg;
    logic [PROD_W-1:0]         acc_reg;
    logic signed [PRICE_W-1:0] s_reg;
    logic [DIV_W-1:0]          numer_reg;
    logic [DIV_W-1:0]          quo_reg;
    logic [REM_W-1:0]          rem_reg;
    logic                      rneg_reg;
    logic signed [PRICE_W-1:0] ret_reg;
    logic [MAG_W-1:0]          growth_reg;
    logic                      gneg_reg;
    logic signed [PRICE_W-1:0] prior_close_reg;
    logic                      prior_valid_reg;
    logic signed [PRICE_W-1:0] index_reg;
    result_t                   res_reg;

    logic [MAG_W-1:0]           a_mag;
    logic [MAG_W-1:0]           b_mag;
    logic                       mneg;
    logic [PROD_W-1:0]          prod_sh;
    logic signed [PRICE_W-1:0]  divd;
    logic [1:0]                 chunk_idx;
    logic [CHUNK_W-1:0]         b_part;
    logic [MAG_W+CHUNK_W-1:0]   part;
    logic signed [PRICE_W-1:0]  mul_res;
    logic                       known;
    logic signed [MAG_W+1:0]    num;
    logic [MAG_W:0]             num_mag;
    logic [MAG_W-1:0]           dvs;
    logic [REM_W:0]             t1;
    logic [REM_W:0]             t2;
    logic                       ge1;
    logic                       ge2;
    logic [REM_W-1:0]           r1;
    logic [REM_W-1:0]           r2;
    logic signed [PRICE_W-1:0]  ret_val;
    logic signed [MAG_W:0]      growth;
    logic [MAG_W:0]             growth_neg;

    assign known = smp_reg.close_finite & smp_reg.factor_finite;
    assign divd  = smp_reg.dividend_finite ? smp_reg.dividend_amount : '0;

    always_comb
    begin
        a_mag   = '0;
        b_mag   = '0;
        mneg    = 1'b0;
        prod_sh = '0;
        case (cmd.mul_sel)
            MSEL_CLOSE:
            begin
                a_mag   = mag48(smp_reg.close_price);
                b_mag   = mag48({{(MAG_W-FACTOR_W){smp_reg.split_factor[FACTOR_W-1]}},
                                 smp_reg.split_factor});
                mneg    = smp_reg.close_price[PRICE_W-1] ^ smp_reg.split_factor[FACTOR_W-1];
                prod_sh = acc_reg >> FACTOR_FRAC_BITS;
            end
            MSEL_DIVIDEND:
            begin
                a_mag   = mag48(divd);
                b_mag   = mag48({{(MAG_W-FACTOR_W){smp_reg.split_factor[FACTOR_W-1]}},
                                 smp_reg.split_factor});
                mneg    = divd[PRICE_W-1] ^ smp_reg.split_factor[FACTOR_W-1];
                prod_sh = acc_reg >> FACTOR_FRAC_BITS;
            end
            MSEL_INDEX:
            begin
                a_mag   = mag48(index_reg);
                b_mag   = growth_reg;
                mneg    = index_reg[PRICE_W-1] ^ gneg_reg;
                prod_sh = acc_reg >> RETURN_FRAC_BITS;
            end
            default:
            begin
                a_mag = '0;
            end
        endcase
    end

    // Top chunk of the multiplier operand first.
    assign chunk_idx = 2'(CHUNKS - 1) - cmd.chunk;
    assign b_part    = b_mag[CHUNK_W*chunk_idx +: CHUNK_W];
    assign part      = a_mag * b_part;
    assign mul_res   = sat48(WIDE_W'(prod_sh), mneg);

    assign num     = $signed({{2{s_reg[PRICE_W-1]}}, s_reg})
                   + $signed({{2{mul_res[PRICE_W-1]}}, mul_res})
                   - $signed({{2{prior_close_reg[PRICE_W-1]}}, prior_close_reg});
    assign num_mag = num[MAG_W+1] ? 49'(~num + (MAG_W+2)'(1)) : num[MAG_W:0];

    // Two restoring division steps per cycle.
    assign dvs = prior_close_reg;
    assign t1  = {rem_reg, numer_reg[DIV_W-1]};
    assign ge1 = t1 >= dvs;
    assign r1  = ge1 ? REM_W'(t1 - dvs) : t1[REM_W-1:0];
    assign t2  = {r1, numer_reg[DIV_W-2]};
    assign ge2 = t2 >= dvs;
    assign r2  = ge2 ? REM_W'(t2 - dvs) : t2[REM_W-1:0];

    assign ret_val    = sat48(WIDE_W'(quo_reg), rneg_reg);
    assign growth     = ONE_Q + $signed({ret_val[PRICE_W-1], ret_val});
    assign growth_neg = ~growth + (MAG_W+1)'(1);

    assign status.cell_ok  = known && (s_reg > 0);
    assign status.chain_ok = prior_valid_reg && (prior_close_reg > 0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_close_reg <= '0;
            prior_valid_reg <= 1'b0;
            index_reg       <= '0;
        end
        else
        begin
            if (cmd.load_sample && sample_data.series_start)
                prior_valid_reg <= 1'b0;
            if (cmd.out_write)
            begin
                if (!status.cell_ok)
                begin
                    prior_valid_reg <= 1'b0;
                end
                else if (!status.chain_ok)
                begin
                    index_reg       <= s_reg;
                    prior_close_reg <= s_reg;
                    prior_valid_reg <= 1'b1;
                end
                else
                begin
                    index_reg       <= mul_res;
                    prior_close_reg <= s_reg;
                    prior_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
            smp_reg <= sample_data;
        if (cmd.mul_clear)
            acc_reg <= '0;
        else if (cmd.mul_step)
            acc_reg <= (acc_reg << CHUNK_W) + PROD_W'(part);
        if (cmd.s_capture)
            s_reg <= known ? mul_res : '0;
        if (cmd.div_load)
        begin
            numer_reg <= DIV_W'({num_mag, {RETURN_FRAC_BITS{1'b0}}});
            quo_reg   <= '0;
            rem_reg   <= '0;
            rneg_reg  <= num[MAG_W+1];
        end
        else if (cmd.div_step)
        begin
            numer_reg <= numer_reg << 2;
            quo_reg   <= {quo_reg[DIV_W-3:0], ge1, ge2};
            rem_reg   <= r2;
        end
        if (cmd.ret_capture)
        begin
            ret_reg    <= ret_val;
            gneg_reg   <= growth[MAG_W];
            growth_reg <= growth[MAG_W] ? growth_neg[MAG_W-1:0] : growth[MAG_W-1:0];
        end
        if (cmd.out_write)
        begin
            res_reg.adjusted_close <= s_reg;
            res_reg.adjusted_known <= known;
            res_reg.cell_valid     <= status.cell_ok;
            if (!status.cell_ok)
            begin
                res_reg.daily_return <= '0;
                res_reg.index_level  <= '0;
            end
            else if (!status.chain_ok)
            begin
                res_reg.daily_return <= '0;
                res_reg.index_level  <= s_reg;
            end
            else
            begin
                res_reg.daily_return <= ret_reg;
                res_reg.index_level  <= mul_res;
            end
        end
    end

    assign result_data = res_reg;

endmodule

FILE: hw/rtl/trc_control.sv
`include "total_return_index_chain_macros.svh"

module trc_control #(
    parameter int RETURN_FRAC_BITS = trc_pkg::RETURN_FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_ready,
    output logic                result_valid,
    input  logic                result_ready,
    input  trc_pkg::dp_status_t status,
    output trc_pkg::cmd_t       cmd
);
    import trc_pkg::*;

    localparam int NUM_W     = MAG_W + 1 + RETURN_FRAC_BITS;
    localparam int DIV_W     = NUM_W + (NUM_W % 2);
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_S_MUL  = 10'b00_0000_0010,
        ST_S_EVAL = 10'b00_0000_0100,
        ST_DECIDE = 10'b00_0000_1000,
        ST_D_MUL  = 10'b00_0001_0000,
        ST_D_EVAL = 10'b00_0010_0000,
        ST_DIV    = 10'b00_0100_0000,
        ST_R_EVAL = 10'b00_1000_0000,
        ST_I_MUL  = 10'b01_0000_0000,
        ST_FIN    = 10'b10_0000_0000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    assign out_free     = !out_valid_reg || result_ready;
    assign sample_ready = (state_reg == ST_IDLE);
    assign result_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.chunk  = cnt_reg[1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.load_sample = 1'b1;
                    cmd.mul_clear   = 1'b1;
                    cnt_next        = '0;
                    state_next      = ST_S_MUL;
                end
            end
            ST_S_MUL:
            begin
                cmd.mul_sel  = MSEL_CLOSE;
                cmd.mul_step = 1'b1;
                if (cnt_reg == CNT_W'(CHUNKS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_S_EVAL;
                end
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_S_EVAL:
            begin
                cmd.mul_sel   = MSEL_CLOSE;
                cmd.s_capture = 1'b1;
                cmd.mul_clear = 1'b1;
                state_next    = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                // Gap and anchor cells skip the return arithmetic.
                if (status.cell_ok && status.chain_ok)
                    state_next = ST_D_MUL;
                else
                    state_next = ST_FIN;
            end
            ST_D_MUL:
            begin
                cmd.mul_sel  = MSEL_DIVIDEND;
                cmd.mul_step = 1'b1;
                if (cnt_reg == CNT_W'(CHUNKS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_D_EVAL;
                end
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_D_EVAL:
            begin
                cmd.mul_sel   = MSEL_DIVIDEND;
                cmd.div_load  = 1'b1;
                cmd.mul_clear = 1'b1;
                cnt_next      = '0;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_R_EVAL;
                end
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_R_EVAL:
            begin
                cmd.ret_capture = 1'b1;
                state_next      = ST_I_MUL;
            end
            ST_I_MUL:
            begin
                cmd.mul_sel  = MSEL_INDEX;
                cmd.mul_step = 1'b1;
                if (cnt_reg == CNT_W'(CHUNKS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_FIN;
                end
                else
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            ST_FIN:
            begin
                cmd.mul_sel = MSEL_INDEX;
                if (out_free)
                begin
                    cmd.out_write = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && result_ready)
            out_valid_next = 1'b0;
        if (cmd.out_write)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `TRC_ASSERT_IMPL(a_write_needs_slot, cmd.out_write, !out_valid_reg || result_ready, "result overwritten")
    `TRC_ASSERT_NEXT(a_accept_starts_mul, (state_reg == ST_IDLE) && sample_valid, state_reg == ST_S_MUL, "accept did not start")
    `TRC_ASSERT_IMPL(a_div_count_bound, state_reg == ST_DIV, cnt_reg < DIV_STEPS, "divider overran")
    `TRC_ASSERT(a_one_unit_busy, !(cmd.mul_step && cmd.div_step), "multiplier and divider both stepping")

endmodule

FILE: hw/rtl/total_return_index_chain.sv
// Channel  Dir  Word      Handshake
// sample   in   sample_t  valid/ready, accepted when both high
// result   out  result_t  valid/ready, accepted when both high
//
// Gap and anchor cells skip the dividend product, the divide and the index product;
// chained cells run every step, and the two-bit-per-cycle return divider is the
// longest of them.
// Reset clears the anchor, the prior close and the running index at once.
// A finished word waits in the output register; the next sample is taken
// meanwhile, and the block holds in its last step until that register frees.
module total_return_index_chain #(
    parameter int RETURN_FRAC_BITS = trc_pkg::RETURN_FRAC_BITS_DEF
) (
    input logic         clk,
    input logic         rst_n,
    trc_stream_if.sink   sample,
    trc_stream_if.source result
);
    import trc_pkg::*;

    cmd_t       cmd;
    dp_status_t status;
    result_t    res_data;

    // Sequence the cell: close product, then for chained cells dividend product, divide, index product.
    trc_control #(
        .RETURN_FRAC_BITS(RETURN_FRAC_BITS)
    ) u_control (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample.valid),
        .sample_ready (sample.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .status       (status),
        .cmd          (cmd)
    );

    // Hold the chain state and the shared multiplier and divider.
    trc_datapath #(
        .RETURN_FRAC_BITS(RETURN_FRAC_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sample_data (sample.data),
        .status      (status),
        .result_data (res_data)
    );

    assign result.data = res_data;

endmodule

FILE: tb/tb_total_return_index_chain.sv
`timescale 1ns / 1ps

class index_scoreboard;
    trc_pkg::result_t pending[$];
    logic signed [47:0] last_close;
    logic               anchored;
    logic signed [47:0] chain_index;
    int                 mismatches;

    function new();
        last_close  = '0;
        anchored    = 1'b0;
        chain_index = '0;
        mismatches  = 0;
    endfunction

    // Scale a signed product down by sh bits, truncating the magnitude.
    static function logic signed [47:0] scaled_product(input logic signed [63:0] a,
                                                       input logic signed [63:0] b,
                                                       input int sh);
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic [127:0] p;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        p  = ({64'd0, ma} * {64'd0, mb}) >> sh;
        return trc_pkg::sat48(p, a[63] != b[63]);
    endfunction

    // Advance the chain by one cell and queue the word it must produce.
    function void note_sample(input trc_pkg::sample_t c);
        trc_pkg::result_t   r;
        logic signed [63:0] divd;
        logic signed [63:0] net;
        logic [127:0]       q;
        logic [63:0]        mnet;
        r = '0;
        divd = c.dividend_finite ? 64'(c.dividend_amount) : 64'sd0;
        if (c.series_start)
            anchored = 1'b0;
        r.adjusted_known = c.close_finite && c.factor_finite;
        if (r.adjusted_known)
            r.adjusted_close = scaled_product(64'(c.close_price), 64'(c.split_factor), 24);
        r.cell_valid = r.adjusted_known && (r.adjusted_close > 0);
        if (!r.cell_valid)
            anchored = 1'b0;
        else if (!anchored || last_close <= 0)
        begin
            chain_index   = r.adjusted_close;
            r.index_level = r.adjusted_close;
            last_close    = r.adjusted_close;
            anchored      = 1'b1;
        end
        else
        begin
            net = 64'(r.adjusted_close)
                + 64'(scaled_product(divd, 64'(c.split_factor), 24)) - 64'(last_close);
            mnet = net[63] ? -net : net;
            q = ({64'd0, mnet} << 32) / {64'd0, 64'(last_close)};
            r.daily_return = trc_pkg::sat48(q, net[63]);
            chain_index = scaled_product(64'(chain_index),
                                         (64'sd1 <<< 32) + 64'(r.daily_return), 32);
            r.index_level = chain_index;
            last_close    = r.adjusted_close;
        end
        pending.push_back(r);
    endfunction

    function void check_word(input trc_pkg::result_t got);
        trc_pkg::result_t want;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result word %h", got);
            return;
        end
        want = pending.pop_front();
        if (got.adjusted_close !== want.adjusted_close
            || got.adjusted_known !== want.adjusted_known
            || got.daily_return !== want.daily_return
            || got.index_level !== want.index_level
            || got.cell_valid !== want.cell_valid)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: S %h/%h known %b/%b r %h/%h idx %h/%h valid %b/%b",
                         want.adjusted_close, got.adjusted_close,
                         want.adjusted_known, got.adjusted_known,
                         want.daily_return, got.daily_return,
                         want.index_level, got.index_level,
                         want.cell_valid, got.cell_valid);
        end
    endfunction
endclass

module tb_total_return_index_chain;
    import trc_pkg::*;

    localparam int RANDOM_CELLS  = 1250;
    localparam int STALL_LIMIT   = 20000;
    localparam int DRAIN_CYCLES  = 100;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic quiet_tail = 1'b0;
    logic hold_off = 1'b0;
    int   idle_cycles = 0;
    int   ready_gap = 0;

    trc_stream_if #(.T(sample_t)) sample ();
    trc_stream_if #(.T(result_t)) result ();

    index_scoreboard board = new();

    total_return_index_chain dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample.sink),
        .result (result.source)
    );

    always #2 clk = ~clk;

    initial
    begin
        sample.valid = 1'b0;
        sample.data  = '0;
        result.ready = 1'b0;
    end

    // Push one cell through the input handshake, with an occasional random gap first.
    task automatic send_cell(input sample_t c);
        int gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            sample.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample.valid <= 1'b1;
        sample.data  <= c;
        @(posedge clk);
        while (!sample.ready)
            @(posedge clk);
        board.note_sample(c);
    endtask

    function automatic sample_t plain_cell(input logic [47:0] close, input logic [39:0] factor,
                                           input logic [47:0] divd, input logic start);
        sample_t c;
        c.series_start    = start;
        c.close_price     = close;
        c.close_finite    = 1'b1;
        c.split_factor    = factor;
        c.factor_finite   = 1'b1;
        c.dividend_amount = divd;
        c.dividend_finite = 1'b1;
        return c;
    endfunction

    function automatic logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    // Mostly sane price paths with factors between one and five; now and then wild values and broken cells.
    function automatic sample_t random_cell();
        sample_t c;
        int kind;
        kind = $urandom_range(0, 99);
        c = plain_cell(48'($urandom_range(1, 500)) << 16 | 48'($urandom_range(0, 65535)),
                       40'($urandom_range(1, 4)) << 24 | 40'($urandom_range(0, 1 << 24)),
                       ($urandom_range(0, 9) == 0) ? 48'($urandom_range(0, 300000)) : 48'd0,
                       $urandom_range(0, 29) == 0);
        c.dividend_finite = $urandom_range(0, 7) != 0;
        if (kind < 8)
        begin
            c.close_price     = rand48();
            c.split_factor    = 40'({$urandom(), $urandom()});
            c.dividend_amount = rand48();
        end
        else if (kind < 12)
            c.close_finite = 1'b0;
        else if (kind < 15)
            c.factor_finite = 1'b0;
        else if (kind < 18)
            c.close_price = -c.close_price;
        else if (kind < 21)
            c.dividend_amount = -c.dividend_amount;
        return c;
    endfunction

    // Result side: accept words, stall in random bursts, and honor a long hold-off.
    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
            board.check_word(result.data);
        if (!rst_n || hold_off)
            result.ready <= 1'b0;
        else if (ready_gap > 0)
        begin
            result.ready <= 1'b0;
            ready_gap    <= ready_gap - 1;
        end
        else if (!quiet_tail && $urandom_range(0, 4) == 0)
        begin
            result.ready <= 1'b0;
            ready_gap    <= $urandom_range(0, 5);
        end
        else
            result.ready <= 1'b1;
    end

    // Watchdog: count cycles with no word moved on either side.
    always @(posedge clk)
    begin
        if ((sample.valid && sample.ready) || (result.valid && result.ready))
            idle_cycles <= 0;
        else if (rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        sample_t c;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: anchor, growth, dividend, drop, gaps, series restart, extremes.
        send_cell(plain_cell(48'd100 << 16, 40'd1 << 24, 48'd0, 1'b1));
        send_cell(plain_cell(48'd110 << 16, 40'd1 << 24, 48'd0, 1'b0));
        send_cell(plain_cell(48'd105 << 16, 40'd1 << 24, 48'd2 << 16, 1'b0));
        send_cell(plain_cell(48'd10 << 16, 40'd1 << 24, -(48'd50 << 16), 1'b0));
        send_cell(plain_cell(48'd50 << 16, 40'd2 << 24, 48'd1 << 16, 1'b0));
        c = plain_cell(48'd50 << 16, 40'd1 << 24, 48'd0, 1'b0);
        c.close_finite = 1'b0;
        send_cell(c);
        send_cell(plain_cell(48'd60 << 16, 40'd1 << 24, 48'd0, 1'b0));
        c.close_finite = 1'b1;
        c.factor_finite = 1'b0;
        send_cell(c);
        send_cell(plain_cell(48'd0, 40'd1 << 24, 48'd0, 1'b0));
        send_cell(plain_cell(-(48'd5 << 16), 40'd1 << 24, 48'd0, 1'b0));
        send_cell(plain_cell(48'd1, 40'd1, 48'd0, 1'b1));
        send_cell(plain_cell(48'h7FFF_FFFF_FFFF, 40'h7F_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 1'b0));
        send_cell(plain_cell(48'h7FFF_FFFF_FFFF, 40'h7F_FFFF_FFFF, 48'h8000_0000_0000, 1'b0));
        send_cell(plain_cell(48'h8000_0000_0000, 40'h80_0000_0000, 48'h8000_0000_0000, 1'b1));
        send_cell(plain_cell(48'd1 << 16, 40'd1 << 24, 48'd0, 1'b1));
        send_cell(plain_cell(48'h7FFF_FFFF_FFFF, 40'd1 << 24, 48'h7FFF_FFFF_FFFF, 1'b0));
        send_cell(plain_cell(48'd1, 40'd1 << 24, 48'd0, 1'b0));
        c = plain_cell(48'd20 << 16, 40'd1 << 24, 48'hFFFF_FFFF_FFFF, 1'b0);
        c.dividend_finite = 1'b0;
        send_cell(c);
        send_cell(plain_cell(48'd20 << 16, 40'd1 << 24, 48'd0, 1'b1));

        // Random body; the long receiver hold-off fires a quarter of the way in.
        for (int n = 0; n < RANDOM_CELLS; n++)
        begin
            if (n == RANDOM_CELLS / 4)
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (400) @(posedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            if (n == RANDOM_CELLS - 200)
                quiet_tail = 1'b1;
            send_cell(random_cell());
        end
        sample.valid <= 1'b0;

        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
